@@ hdl/poly_eval_pkg.sv @@
// Shared types and constants for the Horner polynomial evaluator.
// No dependencies; compile this file first.
`timescale 1ns / 1ps

package poly_eval_pkg;

   localparam int SAMPLE_W       = 16;  // Q1.15 sample
   localparam int DATA_W         = 32;  // Q16.16 coefficients and result
   localparam int DEG_W          = 3;
   localparam int CSR_IDX_W      = 3;
   localparam int FRAC_DROP      = 15;  // product Q17.31 -> Q16.16
   localparam int PROD_W         = DATA_W + SAMPLE_W;
   localparam int MAX_DEGREE_DEF = 6;

   // register indexes on the csr port; coefficient k sits at REG_COEF0 + k
   localparam logic [CSR_IDX_W-1:0] REG_DEGREE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COEF0  = 3'd1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [DATA_W-1:0]   data_type;
   typedef logic signed [PROD_W-1:0]   prod_type;

   localparam data_type DATA_MAX = 32'sh7FFF_FFFF;
   localparam data_type DATA_MIN = 32'sh8000_0000;
   localparam prod_type RND_HALF = prod_type'(1) <<< (FRAC_DROP - 1);

endpackage

@@ hdl/poly_eval_req_if.sv @@
// Sample channel: valid/ready handshake carrying one Q1.15 sample per beat.
// Depends on poly_eval_pkg.
`timescale 1ns / 1ps

interface poly_eval_req_if
   import poly_eval_pkg::*;
   ;
   logic       valid;
   logic       ready;
   sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

@@ hdl/poly_eval_rsp_if.sv @@
// Result channel: valid/ready handshake carrying the value and saturation flag.
// Depends on poly_eval_pkg.
`timescale 1ns / 1ps

interface poly_eval_rsp_if
   import poly_eval_pkg::*;
   ;
   logic     valid;
   logic     ready;
   data_type value;
   logic     saturated;

   modport source (output valid, output value, output saturated, input ready);
   modport sink   (input valid, input value, input saturated, output ready);
endinterface

@@ hdl/polynomial_evaluation.sv @@
// Polynomial evaluator: takes one Q1.15 sample per beat and returns the
// saturated Q16.16 value of the configured polynomial, degree 0 to MAX_DEGREE,
// computed by Horner's rule. The datapath is a pipeline of MAX_DEGREE Horner
// steps, each split into a multiply stage and a round/add/saturate stage, plus
// one entry stage, so samples are pipelined and one sample is accepted each
// cycle while the pipeline is not held by a stalled result.
// Steps above the configured degree pass the accumulator through unchanged.
// The whole pipeline holds while a finished result waits on rsp_bus.ready,
// and req_bus.ready follows that hold. Write degree and coefficients only
// while no samples are in flight. Depends on poly_eval_pkg and the channel
// interfaces.
`timescale 1ns / 1ps

module polynomial_evaluation
   import poly_eval_pkg::*;
#(
   parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   poly_eval_req_if.sink        req_bus,
   poly_eval_rsp_if.source      rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   localparam logic [DEG_W-1:0] DEG_LIMIT = DEG_W'(MAX_DEGREE);

   // configuration
   logic [DEG_W-1:0] deg_ff;
   data_type         coef_ff [0:MAX_DEGREE];
   logic [DEG_W-1:0] deg_eff;

   // entry and post-add stages: index j holds the accumulator after j steps
   logic       vld_ff [0:MAX_DEGREE];
   data_type   acc_ff [0:MAX_DEGREE];
   logic       sat_ff [0:MAX_DEGREE];
   sample_type x_ff   [0:MAX_DEGREE-1];

   // post-multiply stages
   logic       mvld_ff [0:MAX_DEGREE-1];
   prod_type   prod_ff [0:MAX_DEGREE-1];
   data_type   macc_ff [0:MAX_DEGREE-1];
   logic       msat_ff [0:MAX_DEGREE-1];
   sample_type mx_ff   [0:MAX_DEGREE-1];

   data_type   acc_init_in;
   data_type   step_acc_in [0:MAX_DEGREE-1];
   logic       step_sat_in [0:MAX_DEGREE-1];
   prod_type   rnd_w       [0:MAX_DEGREE-1];
   prod_type   sum_w       [0:MAX_DEGREE-1];
   logic       advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         deg_ff <= '0;
         for (int k = 0; k <= MAX_DEGREE; k++) begin
            coef_ff[k] <= '0;
         end
      end else if (csr_we) begin
         if (csr_index == REG_DEGREE) begin
            deg_ff <= csr_wdata[DEG_W-1:0];
         end
         for (int k = 0; k <= MAX_DEGREE; k++) begin
            if (csr_index == CSR_IDX_W'(REG_COEF0 + CSR_IDX_W'(k))) begin
               coef_ff[k] <= data_type'(csr_wdata);
            end
         end
      end
   end

   assign deg_eff = (deg_ff > DEG_LIMIT) ? DEG_LIMIT : deg_ff;

   // hold everything while the output beat is stalled
   assign advance       = !vld_ff[MAX_DEGREE] || rsp_bus.ready;
   assign req_bus.ready = advance;

   always_comb begin
      acc_init_in = coef_ff[0];
      for (int k = 1; k <= MAX_DEGREE; k++) begin
         if (deg_eff == DEG_W'(k)) begin
            acc_init_in = coef_ff[k];
         end
      end
   end

   // step j folds in coefficient MAX_DEGREE-1-j; inactive above the degree
   always_comb begin
      for (int j = 0; j < MAX_DEGREE; j++) begin
         rnd_w[j] = (prod_ff[j] + RND_HALF) >>> FRAC_DROP;
         sum_w[j] = rnd_w[j] + prod_type'(coef_ff[MAX_DEGREE-1-j]);
         if (DEG_W'(MAX_DEGREE - 1 - j) >= deg_eff) begin
            step_acc_in[j] = macc_ff[j];
            step_sat_in[j] = msat_ff[j];
         end else if (sum_w[j] > prod_type'(DATA_MAX)) begin
            step_acc_in[j] = DATA_MAX;
            step_sat_in[j] = 1'b1;
         end else if (sum_w[j] < prod_type'(DATA_MIN)) begin
            step_acc_in[j] = DATA_MIN;
            step_sat_in[j] = 1'b1;
         end else begin
            step_acc_in[j] = sum_w[j][DATA_W-1:0];
            step_sat_in[j] = msat_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= MAX_DEGREE; j++) begin
            vld_ff[j] <= 1'b0;
         end
         for (int j = 0; j < MAX_DEGREE; j++) begin
            mvld_ff[j] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= req_bus.valid;
         for (int j = 0; j < MAX_DEGREE; j++) begin
            mvld_ff[j]  <= vld_ff[j];
            vld_ff[j+1] <= mvld_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         acc_ff[0] <= acc_init_in;
         sat_ff[0] <= 1'b0;
         x_ff[0]   <= req_bus.sample;
         for (int j = 0; j < MAX_DEGREE; j++) begin
            prod_ff[j]  <= prod_type'(acc_ff[j]) * prod_type'(x_ff[j]);
            macc_ff[j]  <= acc_ff[j];
            msat_ff[j]  <= sat_ff[j];
            mx_ff[j]    <= x_ff[j];
            acc_ff[j+1] <= step_acc_in[j];
            sat_ff[j+1] <= step_sat_in[j];
         end
         for (int j = 1; j < MAX_DEGREE; j++) begin
            x_ff[j] <= mx_ff[j-1];
         end
      end
   end

   assign rsp_bus.valid     = vld_ff[MAX_DEGREE];
   assign rsp_bus.value     = acc_ff[MAX_DEGREE];
   assign rsp_bus.saturated = sat_ff[MAX_DEGREE];

endmodule

@@ hdl/poly_eval_checker.sv @@
// Port-level checks for polynomial_evaluation, attached by the bind below.
// Depends on poly_eval_pkg and the top level.
`timescale 1ns / 1ps

module poly_eval_checker
   import poly_eval_pkg::*;
(
   input logic     clock,
   input logic     reset,
   input logic     req_ready,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input data_type rsp_value,
   input logic     rsp_saturated
);

   // a stalled result beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_value) && $stable(rsp_saturated))
      else $error("rsp payload changed while stalled");

   // a stalled output freezes the pipeline, so no sample may enter
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("sample accepted while output stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind polynomial_evaluation poly_eval_checker u_poly_eval_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_value     (rsp_bus.value),
   .rsp_saturated (rsp_bus.saturated)
);
